FILE: rtl/sha256_stream_hasher_defines.svh
// Assertion macros shared by the SHA-256 stream hasher RTL.
// No dependencies; the using module must provide clk and rst.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define SSH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssh check failed: same-cycle implication");

// Antecedent implies consequent in the following cycle, outside reset.
`define SSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssh check failed: next-cycle implication");

`endif

FILE: rtl/ssh_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies.
package ssh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } ssh_item_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/ssh_front.sv
// Front end of the SHA-256 stream hasher: takes input transactions into a short queue.
// Depends on ssh_pkg.
module ssh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssh_pkg::ssh_item_t in_item,
  output logic              q_valid,
  output ssh_pkg::ssh_item_t q_item,
  input  logic              q_pop
);
  import ssh_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  ssh_item_t          slots [QueueDepth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [PtrW:0]      count;
  logic               push;
  logic               pop;

  assign in_stall = (count == (PtrW+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

FILE: rtl/ssh_back.sv
// Back end of the SHA-256 stream hasher: block assembly, padding, compression, digest output.
// Depends on ssh_pkg and sha256_stream_hasher_defines.svh.
module ssh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ssh_pkg::ssh_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word
);
  import ssh_pkg::*;
  `include "sha256_stream_hasher_defines.svh"

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t       state;
  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [23:0]  cur;
  logic [5:0]   fill_count;
  logic [63:0]  message_byte_count;
  logic [63:0]  len_bits;
  logic [5:0]   round;
  logic         padding;
  logic         pad_marked;
  logic [3:0]   len_cnt;

  logic         push_en;
  logic [7:0]   push_byte;
  logic         take_item;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  w_new;
  logic [63:0]  count_next;

  assign take_item = (state == ST_COLLECT) && q_valid;
  assign q_pop     = take_item;
  assign count_next = message_byte_count + 64'(q_item.byte_present);

  always_comb begin
    push_en   = 1'b0;
    push_byte = q_item.data_byte;
    if (take_item) begin
      push_en = q_item.byte_present;
    end else if (state == ST_PAD) begin
      push_en = 1'b1;
      if (!pad_marked) push_byte = PadMarker;
      else if (len_cnt == 4'd0 && fill_count != LenStart) push_byte = 8'h00;
      else push_byte = 8'(len_bits >> (6'd56 - {len_cnt[2:0], 3'b000}));
    end
  end

  assign t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + RoundK[round] + w[0];
  assign t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = w[0] + small_sigma0(w[1]) + w[9] + small_sigma1(w[14]);

  // Message schedule window and byte assembly; block contents need no reset.
  always_ff @(posedge clk) begin
    if (push_en) begin
      cur <= {cur[15:0], push_byte};
      if (fill_count[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= {cur, push_byte};
      end
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_COLLECT;
      fill_count         <= '0;
      message_byte_count <= '0;
      padding            <= 1'b0;
      pad_marked         <= 1'b0;
      len_cnt            <= '0;
      round              <= '0;
      word_index         <= '0;
      out_valid          <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
    end else begin
      if (push_en) fill_count <= fill_count + 1'b1;
      unique case (state)
        ST_COLLECT: begin
          if (take_item) begin
            message_byte_count <= count_next;
            if (q_item.end_of_message) begin
              padding  <= 1'b1;
              len_bits <= {count_next[60:0], 3'b000};
            end
            if (push_en && fill_count == 6'd63) begin
              state <= ST_ROUND;
              round <= '0;
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
            end else if (q_item.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!pad_marked) pad_marked <= 1'b1;
          else if (len_cnt != 4'd0 || fill_count == LenStart) len_cnt <= len_cnt + 1'b1;
          if (fill_count == 6'd63) begin
            state <= ST_ROUND;
            round <= '0;
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
          end
        end
        ST_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 1'b1;
          if (round == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          if (len_cnt == 4'd8) begin
            state      <= ST_EMIT;
            out_valid  <= 1'b1;
            word_index <= '0;
          end else if (padding) begin
            state <= ST_PAD;
          end else begin
            state <= ST_COLLECT;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            word_index <= word_index + 1'b1;
            if (word_index == 3'd7) begin
              out_valid          <= 1'b0;
              state              <= ST_COLLECT;
              message_byte_count <= '0;
              padding            <= 1'b0;
              pad_marked         <= 1'b0;
              len_cnt            <= '0;
              for (int i = 0; i < 8; i++) chain[i] <= IV[i];
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  assign digest_word = chain[word_index];
  assign last_word   = (word_index == 3'd7);

  `SSH_ASSERT_NOW(a_pop_only_collect, q_pop, state == ST_COLLECT)
  `SSH_ASSERT_NOW(a_emit_block_done, out_valid, fill_count == 6'd0 && len_cnt == 4'd8)
  `SSH_ASSERT_NEXT(a_round_start_aligned, state == ST_ADD, fill_count == 6'd0)
  `SSH_ASSERT_NOW(a_len_after_marker, len_cnt != 4'd0, pad_marked && padding)

endmodule

FILE: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher. Synchronous active-high reset empties the queue and restores the IV.
// Bytes enter a four-entry queue one a cycle while in_stall is low; each 64-byte block then goes
// through the compression rounds and a chaining step, in which no byte leaves the queue.
// End of message: padding goes in one byte a cycle, then compression, twice if the length spills
// into a second block; out_valid rises after the last chaining step, then eight words go out one
// a cycle while not stalled.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import ssh_pkg::*;

  // The front queue decouples the byte source from the compression engine, so
  // input transactions keep flowing while a block is being compressed, until
  // the queue fills.
  ssh_item_t in_item;
  ssh_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  assign in_item = '{data_byte: data_byte, byte_present: byte_present,
                     end_of_message: end_of_message};

  ssh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // The back end assembles words into the schedule window, pads the final block
  // with the marker byte, zeros and the bit length, runs one round per cycle and
  // presents the digest from the chaining registers.
  ssh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule
